FILE: hw/rtl/bitplane_sprite_blitter_unit_defines.svh
// ----------------------------------------------------------------------------
// Blitter assertion macros
// Shared concurrent assertion shorthands for the frame buffer writer checks.
// ----------------------------------------------------------------------------
`ifndef BITPLANE_SPRITE_BLITTER_UNIT_DEFINES_SVH
`define BITPLANE_SPRITE_BLITTER_UNIT_DEFINES_SVH

// Check a property only while out of reset.
`define BSB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define BSB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/bsb_pkg.sv
// ----------------------------------------------------------------------------
// Blitter package
// Shared constants, codes and controller/datapath handoff types.
// ----------------------------------------------------------------------------
package bsb_pkg;

    localparam int COLUMNS_DEF     = 64;
    localparam int HALF_PIXELS_DEF = 1024;
    localparam int PLANES_DEF      = 8;

    localparam int WORD_W = 6;

    // Bits kept when the other display half is written.
    localparam logic [WORD_W-1:0] MASK_BOTTOM_RGB = 6'h38;
    localparam logic [WORD_W-1:0] MASK_TOP_RGB    = 6'h07;

    // Request codes
    localparam logic [1:0] REQ_PIXEL = 2'd0;
    localparam logic [1:0] REQ_SWAP  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_WRITTEN = 2'd0;
    localparam logic [1:0] ST_SKIPPED = 2'd1;
    localparam logic [1:0] ST_SWAPPED = 2'd2;
    localparam logic [1:0] ST_READ    = 2'd3;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_ADDR,
        S_CLEAR,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic latch;
        logic rd_en;
        logic clr_en;
        logic clr_all;
        logic flip;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] in_type;
        logic       clr_last;
        logic       slot_free;
    } t_stat;

    function automatic t_state state_for_req(logic [1:0] req);
        t_state s;
        case (req) inside
            REQ_PIXEL, REQ_READ: s = S_ADDR;
            REQ_SWAP:            s = S_CLEAR;
            default:             s = S_FINISH;
        endcase
        return s;
    endfunction

endpackage

FILE: hw/rtl/bsb_if.sv
// ----------------------------------------------------------------------------
// Blitter channels
// Valid/ready request and response channels of the frame buffer writer.
// ----------------------------------------------------------------------------
interface bsb_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic signed [10:0] origin_x;
    logic signed [10:0] origin_y;
    logic [7:0]        sprite_width;
    logic              last_pixel;
    logic [3:0]        level_red;
    logic [3:0]        level_green;
    logic [3:0]        level_blue;
    logic              opaque;
    logic [2:0]        read_plane;
    logic [9:0]        read_address;

    modport source (
        output valid, req_type, origin_x, origin_y, sprite_width, last_pixel,
               level_red, level_green, level_blue, opaque, read_plane, read_address,
        input  ready
    );
    modport sink (
        input  valid, req_type, origin_x, origin_y, sprite_width, last_pixel,
               level_red, level_green, level_blue, opaque, read_plane, read_address,
        output ready
    );
endinterface

interface bsb_rsp_if;
    logic       valid;
    logic       ready;
    logic [5:0] read_data;
    logic [1:0] status;

    modport source (output valid, read_data, status, input ready);
    modport sink (input valid, read_data, status, output ready);
endinterface

FILE: hw/rtl/bsb_ctrl.sv
// ----------------------------------------------------------------------------
// Blitter controller
// Sequences reset clear, pixel read-modify-write, reads and swap clears.
// ----------------------------------------------------------------------------
module bsb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bsb_pkg::t_stat i_stat,
    output bsb_pkg::t_cmd  o_cmd
);

    bsb_pkg::t_state r_state;
    bsb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsb_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            bsb_pkg::S_INIT: begin
                o_cmd.clr_en  = 1'b1;
                o_cmd.clr_all = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = bsb_pkg::S_IDLE;
                end
            end
            bsb_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = bsb_pkg::state_for_req(i_stat.in_type);
                end
            end
            bsb_pkg::S_ADDR: begin
                o_cmd.rd_en = 1'b1;
                n_state     = bsb_pkg::S_FINISH;
            end
            bsb_pkg::S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_stat.clr_last) begin
                    o_cmd.flip = 1'b1;
                    n_state    = bsb_pkg::S_FINISH;
                end
            end
            bsb_pkg::S_FINISH: begin
                // hold the result until the output slot frees up
                if (i_stat.slot_free) begin
                    o_cmd.finish   = 1'b1;
                    o_cmd.in_ready = 1'b1;
                    if (i_stat.in_valid) begin
                        o_cmd.latch = 1'b1;
                        n_state     = bsb_pkg::state_for_req(i_stat.in_type);
                    end else begin
                        n_state = bsb_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = bsb_pkg::S_INIT;
            end
        endcase
    end

endmodule

FILE: hw/rtl/bsb_dp.sv
// ----------------------------------------------------------------------------
// Blitter datapath
// Item registers, sprite counters, plane memory and output register.
// ----------------------------------------------------------------------------
module bsb_dp #(
    parameter int COLUMNS     = bsb_pkg::COLUMNS_DEF,
    parameter int HALF_PIXELS = bsb_pkg::HALF_PIXELS_DEF,
    parameter int PLANES      = bsb_pkg::PLANES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bsb_req_if.sink        i_req,
    bsb_rsp_if.source      o_rsp,
    input  bsb_pkg::t_cmd  i_cmd,
    output bsb_pkg::t_stat o_stat
);

    localparam int W   = bsb_pkg::WORD_W;
    localparam int AW  = $clog2(HALF_PIXELS);
    localparam int MAW = AW + 1;
    localparam int RW  = PLANES * W;
    localparam int LW  = 12 + $clog2(COLUMNS + 1);

    // latched item
    logic [1:0]  r_type;
    logic [11:0] r_x;
    logic [11:0] r_y;
    logic [3:0]  r_lvl_r;
    logic [3:0]  r_lvl_g;
    logic [3:0]  r_lvl_b;
    logic        r_opaque;
    logic [2:0]  r_plane;
    logic [9:0]  r_raddr;

    logic [7:0]  r_col;
    logic [7:0]  r_row;
    logic        r_front;
    logic [MAW-1:0] r_clr;

    logic           r_wr_ok;
    logic           r_top;
    logic [MAW-1:0] r_waddr;
    logic [RW-1:0]  r_rd_data;

    logic          r_out_valid;
    logic [W-1:0]  r_out_data;
    logic [1:0]    r_out_status;

    logic [RW-1:0] mem [2**MAW];

    logic [LW-1:0]  lin;
    logic [LW-1:0]  lin_low;
    logic           in_disp;
    logic           fits;
    logic           top;
    logic [AW-1:0]  pix_addr;
    logic [MAW-1:0] rd_addr;
    logic [MAW-1:0] clr_addr;
    logic           clr_last;
    logic           rd_ok;
    logic [W-1:0]   plane_word;
    logic [RW-1:0]  merged;
    logic           we;
    logic [MAW-1:0] wa;
    logic [RW-1:0]  wd;
    logic [W-1:0]   res_data;
    logic [1:0]     res_status;
    logic [8:0]     col_inc;

    assign i_req.ready = i_cmd.in_ready;

    assign o_stat.in_valid  = i_req.valid;
    assign o_stat.in_type   = i_req.req_type;
    assign o_stat.clr_last  = clr_last;
    assign o_stat.slot_free = !r_out_valid || o_rsp.ready;

    assign col_inc = {1'b0, r_col} + 9'd1;

    // item registers and sprite position
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_x      <= {i_req.origin_x[10], i_req.origin_x} + {4'b0000, r_col};
            r_y      <= {i_req.origin_y[10], i_req.origin_y} + {4'b0000, r_row};
            r_lvl_r  <= i_req.level_red;
            r_lvl_g  <= i_req.level_green;
            r_lvl_b  <= i_req.level_blue;
            r_opaque <= i_req.opaque;
            r_plane  <= i_req.read_plane;
            r_raddr  <= i_req.read_address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type  <= bsb_pkg::REQ_PIXEL;
            r_col   <= '0;
            r_row   <= '0;
            r_front <= 1'b0;
            r_clr   <= '0;
        end else begin
            if (i_cmd.latch) begin
                r_type <= i_req.req_type;
                if (i_req.req_type == bsb_pkg::REQ_PIXEL) begin
                    if (i_req.last_pixel) begin
                        r_col <= '0;
                        r_row <= '0;
                    end else if (col_inc >= {1'b0, i_req.sprite_width}) begin
                        r_col <= '0;
                        r_row <= r_row + 8'd1;
                    end else begin
                        r_col <= col_inc[7:0];
                    end
                end
            end
            if (i_cmd.flip) begin
                r_front <= ~r_front;
            end
            if (i_cmd.clr_en) begin
                r_clr <= clr_last ? '0 : r_clr + MAW'(1);
            end
        end
    end

    // pixel placement
    assign lin      = LW'(r_y[10:0]) * LW'(COLUMNS) + LW'(r_x[10:0]);
    assign lin_low  = lin - LW'(HALF_PIXELS);
    assign in_disp  = r_opaque && !r_x[11] && (r_x < 12'(COLUMNS)) && !r_y[11];
    assign fits     = lin < LW'(2 * HALF_PIXELS);
    assign top      = lin < LW'(HALF_PIXELS);
    assign pix_addr = top ? lin[AW-1:0] : lin_low[AW-1:0];

    assign rd_addr  = (r_type == bsb_pkg::REQ_READ) ? {r_front, AW'(r_raddr)}
                                                    : {~r_front, pix_addr};
    assign clr_addr = i_cmd.clr_all ? r_clr : {r_front, r_clr[AW-1:0]};
    assign clr_last = i_cmd.clr_all ? (r_clr == '1)
                                    : (r_clr[AW-1:0] == AW'(HALF_PIXELS - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_wr_ok <= in_disp && fits;
            r_top   <= top;
            r_waddr <= {~r_front, pix_addr};
        end
    end

    // plane memory: one row holds the word of every plane
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_comb begin
        logic [2:0]   bits;
        logic [W-1:0] old;
        merged = '0;
        for (int p = 0; p < PLANES; p++) begin
            bits = {r_lvl_b > 4'(p), r_lvl_g > 4'(p), r_lvl_r > 4'(p)};
            old  = r_rd_data[p*W +: W];
            merged[p*W +: W] = r_top ? ((old & bsb_pkg::MASK_BOTTOM_RGB) | {3'b000, bits})
                                     : ((old & bsb_pkg::MASK_TOP_RGB) | {bits, 3'b000});
        end
    end

    assign we = i_cmd.clr_en
             || (i_cmd.finish && (r_type == bsb_pkg::REQ_PIXEL) && r_wr_ok);
    assign wa = i_cmd.clr_en ? clr_addr : r_waddr;
    assign wd = i_cmd.clr_en ? '0 : merged;

    // read result
    assign rd_ok = (4'(r_plane) < 4'(PLANES)) && (14'(r_raddr) < 14'(HALF_PIXELS));

    always_comb begin
        plane_word = '0;
        for (int p = 0; p < PLANES; p++) begin
            if (r_plane == 3'(p)) begin
                plane_word = r_rd_data[p*W +: W];
            end
        end
    end

    always_comb begin
        res_data = '0;
        case (r_type)
            bsb_pkg::REQ_PIXEL: res_status = r_wr_ok ? bsb_pkg::ST_WRITTEN
                                                     : bsb_pkg::ST_SKIPPED;
            bsb_pkg::REQ_SWAP:  res_status = bsb_pkg::ST_SWAPPED;
            bsb_pkg::REQ_READ: begin
                res_status = bsb_pkg::ST_READ;
                res_data   = rd_ok ? plane_word : '0;
            end
            default:            res_status = bsb_pkg::ST_SKIPPED;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_data   <= res_data;
            r_out_status <= res_status;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_data = r_out_data;
    assign o_rsp.status    = r_out_status;

endmodule

FILE: hw/rtl/bitplane_sprite_blitter_unit.sv
// ----------------------------------------------------------------------------
// Bitplane sprite blitter
// Double-buffered bit-plane frame buffer writer for a split-scan LED matrix.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one beat per request: a sprite pixel (placed by internal
//   column/row counters that wrap at sprite_width and reset after
//   last_pixel), a swap (exchange front and back, clear the new back), or
//   a read of one front-buffer word. o_rsp returns one beat per request with
//   read_data and a status code.
//   Pixel and read beats pass from accept through S_ADDR (the row read) to
//   S_FINISH, which loads the result once the output register is free; the
//   next beat is accepted in the cycle the result is loaded. A pixel is a
//   row read, then a merged row write, through the single read and write
//   port of the plane memory. A swap walks HALF_PIXELS rows, one per cycle,
//   then loads its result; unknown request codes go straight to S_FINISH.
//   After reset the block clears all 2**(clog2(HALF_PIXELS)+1) rows of the
//   plane memory (2048 at the default size), with i_req.ready low.
//   When o_rsp stalls, the finished result holds in the output register;
//   one more beat can be accepted, and its result waits until that is taken.
// ----------------------------------------------------------------------------
module bitplane_sprite_blitter_unit #(
    parameter int COLUMNS     = bsb_pkg::COLUMNS_DEF,
    parameter int HALF_PIXELS = bsb_pkg::HALF_PIXELS_DEF,
    parameter int PLANES      = bsb_pkg::PLANES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsb_req_if.sink   i_req,
    bsb_rsp_if.source o_rsp
);

    bsb_pkg::t_cmd  cmd;
    bsb_pkg::t_stat stat;

    // sequencing: reset clear, read/merge/write, swap clear, result handoff
    bsb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // counters, plane memory and output register
    bsb_dp #(
        .COLUMNS     (COLUMNS),
        .HALF_PIXELS (HALF_PIXELS),
        .PLANES      (PLANES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

endmodule

FILE: hw/rtl/bsb_chk.sv
// ----------------------------------------------------------------------------
// Blitter checker
// Port-level assertions, bound to the blitter top level.
// ----------------------------------------------------------------------------
`include "bitplane_sprite_blitter_unit_defines.svh"

module bsb_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic [1:0] i_req_type,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic [5:0] i_rsp_data,
    input logic [1:0] i_rsp_status
);

    `BSB_ASSERT_ALWAYS(a_init_blocks_req, i_clk, !i_rst_n |=> !i_req_ready, "ready right after reset")
    `BSB_ASSERT(a_swap_clears, i_clk, i_rst_n, (i_req_valid && i_req_ready && (i_req_type == bsb_pkg::REQ_SWAP)) |=> !i_req_ready, "beat accepted during swap clear")
    `BSB_ASSERT(a_data_only_on_read, i_clk, i_rst_n, (i_rsp_valid && (i_rsp_status != bsb_pkg::ST_READ)) |-> (i_rsp_data == 6'd0), "nonzero data on non-read beat")
    `BSB_ASSERT(a_rsp_holds, i_clk, i_rst_n, (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_data) && $stable(i_rsp_status)), "stalled response changed")

endmodule

bind bitplane_sprite_blitter_unit bsb_chk u_bsb_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_req_type   (i_req.req_type),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_data   (o_rsp.read_data),
    .i_rsp_status (o_rsp.status)
);

FILE: test/frame_buffer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame buffer checker
// Watches the request and response channels of the blitter. Mirrors both
// bit-plane banks, the front select and the sprite counters. Predicts every
// response beat and compares each one when it is taken.
// ----------------------------------------------------------------------------
module frame_buffer_checker
    import bsb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    bsb_req_if   i_req,
    bsb_rsp_if   i_rsp,
    output int   o_mismatches,
    output int   o_outstanding
);

    localparam int COLUMNS     = COLUMNS_DEF;
    localparam int HALF_PIXELS = HALF_PIXELS_DEF;
    localparam int PLANES      = PLANES_DEF;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic [1:0]        status;
    } response_t;

    logic [WORD_W-1:0] plane_words [0:1][0:PLANES-1][0:HALF_PIXELS-1];
    logic              front_bank;
    logic [7:0]        column_cnt;
    logic [7:0]        row_cnt;
    response_t         expected_responses [$];
    int                mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    task automatic report(input string msg);
        if (mismatch_count < 40) begin
            $display("%0t ns: MISMATCH %s", $time, msg);
        end
        mismatch_count++;
    endtask

    function automatic void clear_bank(input logic bank);
        for (int p = 0; p < PLANES; p++) begin
            for (int a = 0; a < HALF_PIXELS; a++) begin
                plane_words[bank][p][a] = '0;
            end
        end
    endfunction

    // Apply one request beat to the mirrored state and return its response.
    function automatic response_t predict_response();
        response_t         rsp;
        int                x;
        int                y;
        int                lin;
        int                addr;
        logic              top_half;
        logic              back_bank;
        logic [2:0]        rgb;
        logic [WORD_W-1:0] word;
        rsp.read_data = '0;
        rsp.status    = ST_SKIPPED;
        case (i_req.req_type)
            REQ_PIXEL: begin
                x = $signed(i_req.origin_x) + int'(column_cnt);
                y = $signed(i_req.origin_y) + int'(row_cnt);
                lin = y * COLUMNS + x;
                if (i_req.opaque && x >= 0 && x < COLUMNS && y >= 0
                        && lin < 2 * HALF_PIXELS) begin
                    top_half  = (lin < HALF_PIXELS);
                    addr      = top_half ? lin : lin - HALF_PIXELS;
                    back_bank = ~front_bank;
                    for (int d = 0; d < PLANES; d++) begin
                        rgb  = {i_req.level_blue > d, i_req.level_green > d,
                                i_req.level_red > d};
                        word = plane_words[back_bank][d][addr];
                        if (top_half) begin
                            word = (word & MASK_BOTTOM_RGB) | {3'b000, rgb};
                        end else begin
                            word = (word & MASK_TOP_RGB) | {rgb, 3'b000};
                        end
                        plane_words[back_bank][d][addr] = word;
                    end
                    rsp.status = ST_WRITTEN;
                end
                // advance the raster counters; width zero acts as width one
                if (i_req.last_pixel) begin
                    column_cnt = '0;
                    row_cnt    = '0;
                end else if (int'(column_cnt) + 1 >= int'(i_req.sprite_width)) begin
                    column_cnt = '0;
                    row_cnt    = row_cnt + 8'd1;
                end else begin
                    column_cnt = column_cnt + 8'd1;
                end
            end
            REQ_SWAP: begin
                clear_bank(front_bank);
                front_bank = ~front_bank;
                rsp.status = ST_SWAPPED;
            end
            REQ_READ: begin
                if (i_req.read_plane < PLANES && i_req.read_address < HALF_PIXELS) begin
                    rsp.read_data = plane_words[front_bank][i_req.read_plane][i_req.read_address];
                end
                rsp.status = ST_READ;
            end
            default: begin
                rsp.status = ST_SKIPPED;
            end
        endcase
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        response_t want;
        if (!i_rst_n) begin
            clear_bank(1'b0);
            clear_bank(1'b1);
            front_bank = 1'b0;
            column_cnt = '0;
            row_cnt    = '0;
            expected_responses.delete();
        end else begin
            // compare the response first: a request taken on this edge
            // cannot have its result on the same edge
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_responses.size() == 0) begin
                    report($sformatf("response data %0d status %0d with nothing pending",
                                     i_rsp.read_data, i_rsp.status));
                end else begin
                    want = expected_responses.pop_front();
                    if (i_rsp.read_data !== want.read_data) begin
                        report($sformatf("read_data got %0d expected %0d",
                                         i_rsp.read_data, want.read_data));
                    end
                    if (i_rsp.status !== want.status) begin
                        report($sformatf("status got %0d expected %0d",
                                         i_rsp.status, want.status));
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                expected_responses.push_back(predict_response());
            end
        end
        o_outstanding <= expected_responses.size();
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Blitter testbench
// Drives pixel, swap, read and unused request beats into the blitter under
// bursty sender traffic and a patterned receiver stall. A directed opening
// hits the display edges, the split halves, transparency, width zero and the
// origin extremes; the random part streams well-formed sprites, swaps with
// read-back of the drawn words, broken sprites and raw noise. A separate
// checker predicts and compares every response beat.
// ----------------------------------------------------------------------------
module testbench;
    import bsb_pkg::*;

    localparam int         COLUMNS        = COLUMNS_DEF;
    localparam int         HALF_PIXELS    = HALF_PIXELS_DEF;
    localparam int         RANDOM_BEATS   = 400;
    // Reset clear and a swap clear both run with no beats moving; leave
    // plenty of margin on top of receiver stalls.
    localparam int         WATCHDOG_LIMIT = 20000;
    // The request field has one code with no meaning.
    localparam logic [1:0] REQ_UNUSED     = 2'd3;

    typedef struct {
        logic [1:0]        kind;
        logic signed [10:0] origin_x;
        logic signed [10:0] origin_y;
        logic [7:0]        sprite_width;
        logic              last;
        logic [3:0]        level_red;
        logic [3:0]        level_green;
        logic [3:0]        level_blue;
        logic              opaque;
        logic [2:0]        read_plane;
        logic [9:0]        read_address;
    } blit_beat_t;

    typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_CADENCE} rx_mode_t;

    logic      i_clk;
    logic      i_rst_n;
    bsb_req_if req_ch ();
    bsb_rsp_if rsp_ch ();

    int mismatches;
    int outstanding;
    int idle_cycles  = 0;
    int results_seen = 0;
    int burst_left   = 0;
    int beats_sent   = 0;
    int n_pixels     = 0;
    int n_swaps      = 0;
    int n_reads      = 0;
    int n_unused     = 0;
    // Half-display addresses drawn since the last swap, for targeted reads.
    int recent_words [$];

    bitplane_sprite_blitter_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    frame_buffer_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Receiver: hold a stall mode for a random window, then pick another.
    // Open windows give stretches with no back-pressure at all.
    // ------------------------------------------------------------------------
    initial begin
        rx_mode_t mode;
        int       window;
        int       phase;
        mode   = RX_OPEN;
        window = 0;
        phase  = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (window == 0) begin
                mode   = rx_mode_t'($urandom_range(0, 3));
                window = $urandom_range(20, 120);
            end else begin
                window--;
            end
            phase++;
            case (mode)
                RX_OPEN:    rsp_ch.ready <= 1'b1;
                RX_LIGHT:   rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY:   rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                RX_CADENCE: rsp_ch.ready <= (phase % 5 < 2);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no beat moves on either channel for too
    // long. Also count response beats for the summary.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen <= results_seen + 1;
        end
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles without a beat", idle_cycles);
            $display("testbench NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Fill every field at random; callers override what matters.
    function automatic blit_beat_t random_beat();
        blit_beat_t b;
        b.kind         = 2'($urandom_range(0, 3));
        b.origin_x     = 11'($urandom);
        b.origin_y     = 11'($urandom);
        b.sprite_width = 8'($urandom);
        b.last         = 1'($urandom);
        b.level_red    = 4'($urandom);
        b.level_green  = 4'($urandom);
        b.level_blue   = 4'($urandom);
        b.opaque       = 1'($urandom);
        b.read_plane   = 3'($urandom);
        b.read_address = 10'($urandom);
        return b;
    endfunction

    // Mostly legal intensities, now and then the over-range ones.
    function automatic int pick_level();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
    endfunction

    // ------------------------------------------------------------------------
    // Present one beat and hold it until taken. Within a burst the next beat
    // follows at once with valid held high; at the end of a burst drop valid
    // for a random gap and draw a new burst length.
    // ------------------------------------------------------------------------
    task automatic send(input blit_beat_t b);
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= b.kind;
        req_ch.origin_x     <= b.origin_x;
        req_ch.origin_y     <= b.origin_y;
        req_ch.sprite_width <= b.sprite_width;
        req_ch.last_pixel   <= b.last;
        req_ch.level_red    <= b.level_red;
        req_ch.level_green  <= b.level_green;
        req_ch.level_blue   <= b.level_blue;
        req_ch.opaque       <= b.opaque;
        req_ch.read_plane   <= b.read_plane;
        req_ch.read_address <= b.read_address;
        do @(posedge i_clk); while (!req_ch.ready);
        beats_sent++;
        case (b.kind)
            REQ_PIXEL: n_pixels++;
            REQ_SWAP:  n_swaps++;
            REQ_READ:  n_reads++;
            default:   n_unused++;
        endcase
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 14 : 4)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 64)
                                                     : $urandom_range(0, 6);
        end
    endtask

    task automatic send_pixel(input int ox, input int oy, input int w, input bit last,
                              input int r, input int g, input int bl, input bit op);
        blit_beat_t b;
        b              = random_beat();
        b.kind         = REQ_PIXEL;
        b.origin_x     = 11'(ox);
        b.origin_y     = 11'(oy);
        b.sprite_width = 8'(w);
        b.last         = last;
        b.level_red    = 4'(r);
        b.level_green  = 4'(g);
        b.level_blue   = 4'(bl);
        b.opaque       = op;
        send(b);
    endtask

    task automatic send_read(input int plane, input int addr);
        blit_beat_t b;
        b              = random_beat();
        b.kind         = REQ_READ;
        b.read_plane   = 3'(plane);
        b.read_address = 10'(addr);
        send(b);
    endtask

    task automatic send_swap();
        blit_beat_t b;
        b      = random_beat();
        b.kind = REQ_SWAP;
        send(b);
    endtask

    // Hold off the sender until every pending response beat has come back.
    task automatic drain();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // ------------------------------------------------------------------------
    // Stream one sprite in raster order at a random spot around the display.
    // Without termination the counters are left mid-sprite, so the next
    // sprite starts displaced.
    // ------------------------------------------------------------------------
    task automatic draw_sprite(input bit terminated);
        int ox;
        int oy;
        int w;
        int span;
        int count;
        int x;
        int y;
        ox    = $urandom_range(0, COLUMNS + 15) - 8;
        oy    = $urandom_range(0, 37) - 4;
        w     = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 255) : $urandom_range(0, 12);
        span  = (w == 0) ? 1 : w;
        count = (w > 16) ? $urandom_range(1, 24) : span * $urandom_range(1, 4);
        for (int p = 0; p < count; p++) begin
            x = ox + p % span;
            y = oy + p / span;
            if (x >= 0 && x < COLUMNS && y >= 0 && y * COLUMNS + x < 2 * HALF_PIXELS) begin
                recent_words.push_back((y * COLUMNS + x) % HALF_PIXELS);
            end
            send_pixel(ox, oy, w, terminated && p == count - 1,
                       pick_level(), pick_level(), pick_level(), $urandom_range(0, 5) != 0);
        end
        while (recent_words.size() > 48) begin
            void'(recent_words.pop_front());
        end
    endtask

    // Show the drawn bank and read back words of it, mostly ones just drawn.
    task automatic show_and_probe();
        send_swap();
        repeat ($urandom_range(2, 8)) begin
            if (recent_words.size() != 0 && $urandom_range(0, 3) != 0) begin
                send_read($urandom_range(0, 7),
                          recent_words[$urandom_range(0, recent_words.size() - 1)]);
            end else begin
                send_read($urandom_range(0, 7), $urandom_range(0, HALF_PIXELS - 1));
            end
        end
        recent_words.delete();
    endtask

    // ------------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------------
    initial begin
        blit_beat_t b;
        int         goal;
        int         pick;
        int         tall_x;
        bit         tall_done;
        tall_done = 1'b0;

        // drive every input to a known value before the first edge
        i_rst_n             <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= REQ_PIXEL;
        req_ch.origin_x     <= '0;
        req_ch.origin_y     <= '0;
        req_ch.sprite_width <= '0;
        req_ch.last_pixel   <= 1'b0;
        req_ch.level_red    <= '0;
        req_ch.level_green  <= '0;
        req_ch.level_blue   <= '0;
        req_ch.opaque       <= 1'b0;
        req_ch.read_plane   <= '0;
        req_ch.read_address <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed opening ----
        // The first beat waits out the post-reset clear via the handshake.
        send_read(0, 0);                                // freshly cleared front
        send_pixel(0, 0, 1, 1, 8, 0, 15, 1);            // top-left corner
        send_pixel(0, 16, 1, 1, 0, 4, 1, 1);            // bottom half, same word
        send_pixel(63, 31, 1, 1, 15, 15, 15, 1);        // last display pixel
        send_pixel(64, 0, 1, 1, 8, 8, 8, 1);            // off the right edge
        send_pixel(-1, 0, 1, 1, 8, 8, 8, 1);            // off the left edge
        send_pixel(0, -1, 1, 1, 8, 8, 8, 1);            // above the display
        send_pixel(0, 32, 1, 1, 8, 8, 8, 1);            // just past the bottom
        send_pixel(5, 5, 1, 1, 8, 8, 8, 0);             // transparent
        send_pixel(-1024, -1024, 1, 1, 1, 1, 1, 1);     // most negative origin
        send_pixel(1023, 1023, 1, 1, 1, 1, 1, 1);       // most positive origin
        send_pixel(10, 10, 0, 0, 3, 5, 7, 1);           // width zero wraps each
        send_pixel(10, 10, 0, 1, 2, 6, 8, 1);           // pixel onto a new row
        send_pixel(62, 2, 3, 0, 8, 1, 0, 1);            // sprite running off the
        send_pixel(62, 2, 3, 0, 0, 8, 1, 1);            // right edge; the rest
        send_pixel(62, 2, 3, 1, 1, 0, 8, 1);            // of it is still placed
        b      = random_beat();
        b.kind = REQ_UNUSED;
        send(b);
        send_swap();
        send_read(7, 0);                                // red and blue planes
        send_read(0, 0);                                // top and bottom merged
        send_read(7, 1023);
        send_read(3, 714);                              // width-zero second pixel
        send_read(0, 2 * COLUMNS + 63);                 // sprite edge pixel
        drain();
        send_swap();
        send_read(0, 0);                                // old front now cleared

        // ---- random part ----
        goal = beats_sent + RANDOM_BEATS;
        while (beats_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (!tall_done && beats_sent > goal - RANDOM_BEATS / 2) begin
                // One tall single-column sprite, long enough for the row
                // counter to wrap past 255 and fall back above the display.
                tall_done = 1'b1;
                tall_x    = $urandom_range(0, COLUMNS - 1);
                for (int p = 0; p < 262; p++) begin
                    send_pixel(tall_x, -240, 1, p == 261, pick_level(), pick_level(),
                               pick_level(), $urandom_range(0, 3) != 0);
                end
                show_and_probe();
            end else if (pick < 50) begin
                draw_sprite(1'b1);
            end else if (pick < 60) begin
                show_and_probe();
            end else if (pick < 68) begin
                send_read($urandom_range(0, 7), $urandom_range(0, HALF_PIXELS - 1));
            end else if (pick < 75) begin
                draw_sprite(1'b0);
            end else if (pick < 85) begin
                send(random_beat());
            end else if (pick < 92) begin
                b      = random_beat();
                b.kind = REQ_PIXEL;
                send(b);
            end else begin
                drain();
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d request beats: %0d pixels, %0d swaps, %0d reads, %0d unused codes.",
                 beats_sent, n_pixels, n_swaps, n_reads, n_unused);
        $display("Compared %0d response beats, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0 && outstanding == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
